[rtl/lfu_sr_pkg.sv]
// ----------------------------------------------------------------------------
// LFU slot replacer package
// Shared types and default sizes for the LFU slot replacer.
// ----------------------------------------------------------------------------
package lfu_sr_pkg;

    localparam int MAX_SLOTS_DEF    = 32;
    localparam int ID_BITS_DEF      = 8;
    localparam int COUNTER_BITS_DEF = 16;

    // The slot count register is fixed at six bits.
    localparam int                    SLOT_COUNT_W     = 6;
    localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RESET = 6'd32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIX
    } lfu_state_t;

endpackage

[rtl/lfu_slot_replacer_core.sv]
// ----------------------------------------------------------------------------
// LFU slot replacer core
// Least-frequently-used slot replacement with oldest-first tie break,
// built around one slot memory that is scanned once per transaction.
// ----------------------------------------------------------------------------
// The single slot memory sets the pace of each input transaction: its read
// port walks the occupied slots one per cycle, looking for a hit, tracking
// the victim and writing back each slot's aged value, and a final write then
// updates the referenced slot. That final write also waits for as long as an
// earlier result is still stalled at the output. A finished result waits in
// an output register, so the next transaction is accepted while the previous
// result is still stalled. The slot memory needs no clearing after reset;
// only occupied slots are ever read.
module lfu_slot_replacer_core
    import lfu_sr_pkg::*;
#(
    parameter int MAX_SLOTS    = MAX_SLOTS_DEF,
    parameter int ID_BITS      = ID_BITS_DEF,
    parameter int COUNTER_BITS = COUNTER_BITS_DEF,
    localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1)
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    slot_count_we,
    input  logic [SLOT_COUNT_W-1:0] slot_count,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [ID_BITS-1:0]      entry_id,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    hit,
    output logic [IDX_W-1:0]        slot_index,
    output logic                    evicted,
    output logic [ID_BITS-1:0]      evicted_id,
    output logic [CNT_W-1:0]        occupied
);

    localparam int CB     = COUNTER_BITS;
    localparam int WORD_W = ID_BITS + 2 * CB;

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
        return (&v) ? v : CB'(v + 1'b1);
    endfunction

    // Slot memory: {id, use count, age} per slot.
    logic [WORD_W-1:0] mem [MAX_SLOTS];
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    lfu_state_t state_reg, state_next;

    logic [SLOT_COUNT_W-1:0] slot_count_reg, slot_count_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [ID_BITS-1:0]      id_reg, id_next;
    logic [CNT_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]        widx_reg, widx_next;
    logic                    rv_reg, rv_next;

    logic                    hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]        hit_idx_reg, hit_idx_next;
    logic [CB-1:0]           hit_cnt_reg, hit_cnt_next;
    logic [CB-1:0]           hit_age_reg, hit_age_next;

    logic                    vic_valid_reg, vic_valid_next;
    logic [IDX_W-1:0]        vic_idx_reg, vic_idx_next;
    logic [CB-1:0]           vic_cnt_reg, vic_cnt_next;
    logic [CB-1:0]           vic_age_reg, vic_age_next;
    logic [ID_BITS-1:0]      vic_id_reg, vic_id_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    hit_reg, hit_next;
    logic [IDX_W-1:0]        slot_index_reg, slot_index_next;
    logic                    evicted_reg, evicted_next;
    logic [ID_BITS-1:0]      evicted_id_reg, evicted_id_next;
    logic [CNT_W-1:0]        occupied_reg, occupied_next;

    logic [CNT_W-1:0]        n_act;
    logic                    scan_done;
    logic                    fix_go;
    logic [ID_BITS-1:0]      e_id;
    logic [CB-1:0]           e_cnt;
    logic [CB-1:0]           e_age;

    assign e_id  = rdata_reg[WORD_W-1 -: ID_BITS];
    assign e_cnt = rdata_reg[2*CB-1 -: CB];
    assign e_age = rdata_reg[CB-1:0];

    // Slot count as used: zero acts as one, oversized values clamp.
    always_comb
    begin
        if (slot_count_reg == '0)
        begin
            n_act = CNT_W'(1);
        end
        else if (32'(slot_count_reg) > MAX_SLOTS)
        begin
            n_act = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            n_act = CNT_W'(slot_count_reg);
        end
    end

    assign scan_done = (rd_idx_reg == fill_reg) && !rv_reg;
    assign fix_go    = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                if (fix_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        slot_count_next = slot_count_reg;
        fill_next       = fill_reg;
        id_next         = id_reg;
        rd_idx_next     = rd_idx_reg;
        widx_next       = widx_reg;
        rv_next         = 1'b0;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_cnt_next    = hit_cnt_reg;
        hit_age_next    = hit_age_reg;
        vic_valid_next  = vic_valid_reg;
        vic_idx_next    = vic_idx_reg;
        vic_cnt_next    = vic_cnt_reg;
        vic_age_next    = vic_age_reg;
        vic_id_next     = vic_id_reg;
        out_valid_next  = out_valid_reg;
        hit_next        = hit_reg;
        slot_index_next = slot_index_reg;
        evicted_next    = evicted_reg;
        evicted_id_next = evicted_id_reg;
        occupied_next   = occupied_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;

        if (slot_count_we)
        begin
            slot_count_next = slot_count;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    id_next        = entry_id;
                    rd_idx_next    = '0;
                    hit_found_next = 1'b0;
                    vic_valid_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (rd_idx_reg < fill_reg)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next = CNT_W'(rd_idx_reg + 1'b1);
                    widx_next   = rd_idx_reg;
                    rv_next     = 1'b1;
                end
                if (rv_reg)
                begin
                    // Every occupied slot ages by one; the final write fixes
                    // up the referenced slot afterwards.
                    mem_we    = 1'b1;
                    mem_waddr = widx_reg[IDX_W-1:0];
                    mem_wdata = {e_id, e_cnt, sat_inc(e_age)};
                    if (!hit_found_reg && (e_id == id_reg))
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = widx_reg[IDX_W-1:0];
                        hit_cnt_next   = e_cnt;
                        hit_age_next   = sat_inc(e_age);
                    end
                    // Victims come only from the first slot_count slots and
                    // are compared on their ages before this transaction.
                    if ((widx_reg < n_act) &&
                        (!vic_valid_reg || (e_cnt < vic_cnt_reg) ||
                         ((e_cnt == vic_cnt_reg) && (e_age > vic_age_reg))))
                    begin
                        vic_valid_next = 1'b1;
                        vic_idx_next   = widx_reg[IDX_W-1:0];
                        vic_cnt_next   = e_cnt;
                        vic_age_next   = e_age;
                        vic_id_next    = e_id;
                    end
                end
            end
            ST_FIX:
            begin
                if (fix_go)
                begin
                    mem_we          = 1'b1;
                    out_valid_next  = 1'b1;
                    hit_next        = hit_found_reg;
                    evicted_next    = 1'b0;
                    evicted_id_next = '0;
                    occupied_next   = fill_reg;
                    if (hit_found_reg)
                    begin
                        mem_waddr       = hit_idx_reg;
                        mem_wdata       = {id_reg, sat_inc(hit_cnt_reg), hit_age_reg};
                        slot_index_next = hit_idx_reg;
                    end
                    else if (fill_reg < n_act)
                    begin
                        // New slots have count one and age one after aging.
                        mem_waddr       = fill_reg[IDX_W-1:0];
                        mem_wdata       = {id_reg, CB'(1), CB'(1)};
                        slot_index_next = fill_reg[IDX_W-1:0];
                        fill_next       = CNT_W'(fill_reg + 1'b1);
                        occupied_next   = CNT_W'(fill_reg + 1'b1);
                    end
                    else
                    begin
                        mem_waddr       = vic_idx_reg;
                        mem_wdata       = {id_reg, CB'(1), CB'(1)};
                        slot_index_next = vic_idx_reg;
                        evicted_next    = 1'b1;
                        evicted_id_next = vic_id_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_count_reg <= SLOT_COUNT_RESET;
            fill_reg       <= '0;
            rd_idx_reg     <= '0;
            rv_reg         <= 1'b0;
            hit_found_reg  <= 1'b0;
            vic_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_count_reg <= slot_count_next;
            fill_reg       <= fill_next;
            rd_idx_reg     <= rd_idx_next;
            rv_reg         <= rv_next;
            hit_found_reg  <= hit_found_next;
            vic_valid_reg  <= vic_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg         <= id_next;
        widx_reg       <= widx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_cnt_reg    <= hit_cnt_next;
        hit_age_reg    <= hit_age_next;
        vic_idx_reg    <= vic_idx_next;
        vic_cnt_reg    <= vic_cnt_next;
        vic_age_reg    <= vic_age_next;
        vic_id_reg     <= vic_id_next;
        hit_reg        <= hit_next;
        slot_index_reg <= slot_index_next;
        evicted_reg    <= evicted_next;
        evicted_id_reg <= evicted_id_next;
        occupied_reg   <= occupied_next;
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign slot_index = slot_index_reg;
    assign evicted    = evicted_reg;
    assign evicted_id = evicted_id_reg;
    assign occupied   = occupied_reg;

    // A result appears only after the final slot write.
    a_out_after_fix: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIX))
        else $error("result appeared outside the final write");

    // The fill level never passes the built slot count.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= MAX_SLOTS)
        else $error("fill level beyond built slot count");

    // The fill level only grows, one slot at a time.
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |->
            (fill_reg == CNT_W'($past(fill_reg) + 1'b1)))
        else $error("fill level changed by more than one");

    // A transaction is never both a hit and an eviction.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(hit_reg && evicted_reg))
        else $error("hit and eviction in one result");

    // The scan never reads past the occupied slots.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> (32'(mem_raddr) < 32'(fill_reg)))
        else $error("scan read beyond fill level");

endmodule

[verif/lfu_slot_replacer_core_test.sv]
// ----------------------------------------------------------------------------
// LFU slot replacer core testbench
// Drives entry ids through the core under several slot count settings, with
// random bursts on the input side and random stalls on the output side, and
// checks every result against a cycle-free model of the slot table.
// ----------------------------------------------------------------------------
module lfu_slot_replacer_core_test;
    import lfu_sr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS  = MAX_SLOTS_DEF;
    localparam int IDW    = ID_BITS_DEF;
    localparam int CNTW   = COUNTER_BITS_DEF;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int OCC_W  = $clog2(SLOTS + 1);

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] slot_index;
        logic             evicted;
        logic [IDW-1:0]   evicted_id;
        logic [OCC_W-1:0] occupied;
    } lfu_result_t;

    class lfu_scoreboard;
        logic [IDW-1:0]          held_id [SLOTS];
        logic [CNTW-1:0]         hit_count [SLOTS];
        logic [CNTW-1:0]         age [SLOTS];
        int                      filled;
        logic [SLOT_COUNT_W-1:0] limit_reg;
        lfu_result_t             pending_results[$];
        int                      failures;

        function new();
            filled    = 0;
            limit_reg = SLOT_COUNT_RESET;
            failures  = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                held_id[i]   = '0;
                hit_count[i] = '0;
                age[i]       = '0;
            end
        endfunction

        function void set_limit(logic [SLOT_COUNT_W-1:0] v);
            limit_reg = v;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function logic [CNTW-1:0] bump(logic [CNTW-1:0] v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function string fmt_result(lfu_result_t r);
            return $sformatf("hit=%0d idx=%0d ev=%0d evid=%0d occ=%0d",
                             r.hit, r.slot_index, r.evicted, r.evicted_id,
                             r.occupied);
        endfunction

        // Works out the slot table update for one accepted entry id.
        function void note_reference(logic [IDW-1:0] id);
            int          active;
            int          fill;
            int          idx;
            int          scan_end;
            bit          found;
            lfu_result_t r;

            active = int'(limit_reg);
            if (active == 0)
                active = 1;
            if (active > SLOTS)
                active = SLOTS;
            fill  = filled;
            found = 1'b0;
            idx   = 0;
            r     = '0;
            for (int i = 0; i < fill; i++)
            begin
                if (!found && held_id[i] == id)
                begin
                    found = 1'b1;
                    idx   = i;
                end
            end
            if (found)
            begin
                r.hit          = 1'b1;
                hit_count[idx] = bump(hit_count[idx]);
            end
            else if (fill < active)
            begin
                idx            = fill;
                held_id[idx]   = id;
                hit_count[idx] = CNTW'(1);
                age[idx]       = '0;
                fill++;
            end
            else
            begin
                // The victim is picked only among the first active slots, even
                // when more slots are filled than the limit now allows.
                scan_end = (active < fill) ? active : fill;
                idx = 0;
                for (int i = 1; i < scan_end; i++)
                begin
                    if (hit_count[i] < hit_count[idx] ||
                        (hit_count[i] == hit_count[idx] && age[i] > age[idx]))
                        idx = i;
                end
                r.evicted      = 1'b1;
                r.evicted_id   = held_id[idx];
                held_id[idx]   = id;
                hit_count[idx] = CNTW'(1);
                age[idx]       = '0;
            end
            for (int i = 0; i < fill; i++)
                age[i] = bump(age[i]);
            filled       = fill;
            r.slot_index = idx[IDX_W-1:0];
            r.occupied   = fill[OCC_W-1:0];
            pending_results = {pending_results, r};
        endfunction

        function void check_result(lfu_result_t got);
            lfu_result_t want;

            if (pending_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result with no transaction outstanding: %s",
                             $realtime, fmt_result(got));
                return;
            end
            want = pending_results.pop_front();
            if (got.hit !== want.hit || got.slot_index !== want.slot_index ||
                got.evicted !== want.evicted || got.evicted_id !== want.evicted_id ||
                got.occupied !== want.occupied)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch: expected %s, got %s",
                             $realtime, fmt_result(want), fmt_result(got));
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    slot_count_we;
    logic [SLOT_COUNT_W-1:0] slot_count;
    logic                    in_valid;
    logic                    in_stall;
    logic [IDW-1:0]          entry_id;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    hit;
    logic [IDX_W-1:0]        slot_index;
    logic                    evicted;
    logic [IDW-1:0]          evicted_id;
    logic [OCC_W-1:0]        occupied;

    lfu_scoreboard sb;
    int            burst_left;
    int            stall_mode = 0;
    int            stall_mode_left = 0;
    int            stall_phase = 0;

    lfu_slot_replacer_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .slot_count_we (slot_count_we),
        .slot_count    (slot_count),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .entry_id      (entry_id),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .slot_index    (slot_index),
        .evicted       (evicted),
        .evicted_id    (evicted_id),
        .occupied      (occupied)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // The receiver switches at random between no stalls, random stalls and a fixed periodic pattern.
    always @(posedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode      <= $urandom_range(0, 2);
            stall_mode_left <= $urandom_range(64, 256);
        end
        else
            stall_mode_left <= stall_mode_left - 1;
        stall_phase <= (stall_phase == 6) ? 0 : stall_phase + 1;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 2) == 0);
            default: out_stall <= (stall_phase < 3);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{hit, slot_index, evicted, evicted_id, occupied});
    end

    // Presents one entry id and holds it until the transaction is accepted,
    // then, at the end of a burst, may open a gap before the next burst.
    task automatic send_ref(input logic [IDW-1:0] id);
        int gap;

        in_valid <= 1'b1;
        entry_id <= id;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_reference(id);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 20);
            if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(4, 45);
            else
                gap = $urandom_range(0, 3);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic set_slot_count(input logic [SLOT_COUNT_W-1:0] v);
        drain();
        repeat (6) @(posedge clk);
        slot_count_we <= 1'b1;
        slot_count    <= v;
        @(posedge clk);
        sb.set_limit(v);
        slot_count_we <= 1'b0;
    endtask

    // Mostly draws ids from a small window so that hits and count ties happen,
    // with some fully random ids mixed in.
    function automatic logic [IDW-1:0] pick_id(int base, int span);
        if ($urandom_range(0, 99) < 85)
            return IDW'(base + $urandom_range(0, span - 1));
        return IDW'($urandom_range(0, 255));
    endfunction

    task automatic random_refs(input int items, input int span, input bit pause_mid);
        int base;

        base = $urandom_range(0, 255);
        for (int i = 0; i < items; i++)
        begin
            if (pause_mid && i == items / 2)
                drain();
            send_ref(pick_id(base, span));
        end
    endtask

    initial
    begin
        sb              = new();
        rst_n           = 1'b0;
        slot_count_we   = 1'b0;
        slot_count      = '0;
        in_valid        = 1'b0;
        entry_id        = '0;
        burst_left      = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A zero slot count behaves as a single slot.
        set_slot_count(6'd0);
        send_ref(8'd0);
        send_ref(8'd0);
        send_ref(8'd255);
        send_ref(8'd255);
        send_ref(8'd0);
        random_refs(80, 4, 1'b0);

        set_slot_count(6'd1);
        random_refs(80, 4, 1'b0);

        set_slot_count(6'd4);
        random_refs(200, 8, 1'b0);

        // An oversized slot count behaves as the full table.
        set_slot_count(6'd63);
        send_ref(8'd255);
        send_ref(8'd128);
        send_ref(8'd127);
        send_ref(8'd128);
        send_ref(8'd1);
        random_refs(200, 48, 1'b0);

        set_slot_count(6'd32);
        random_refs(300, 40, 1'b0);

        // Limit below the fill level: hits may land above the limit, victims
        // come only from the low slots.
        set_slot_count(6'd5);
        send_ref(sb.held_id[sb.filled - 1]);
        send_ref(8'hAA);
        send_ref(8'h55);
        send_ref(sb.held_id[sb.filled / 2]);
        random_refs(250, 40, 1'b0);

        set_slot_count(6'd17);
        random_refs(200, 36, 1'b0);

        set_slot_count(6'd32);
        random_refs(130, 64, 1'b1);

        drain();
        repeat (50) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
